// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the caster's modules.
// Each macro expects clk_i and rst_ni in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RGC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgc assertion failed");

// Next-cycle implication, checked outside reset.
`define RGC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgc assertion failed");

`endif

// ----- rtl/rgc_pkg.sv -----
// ----------------------------------------------------------------------------
// rgc_pkg
// Shared constants, codes and helpers of the grid ray column caster.
// ----------------------------------------------------------------------------
`default_nettype none

package rgc_pkg;

  // Map geometry.
  localparam int MapSide   = 16;
  localparam int CellCount = MapSide * MapSide;
  localparam int CellAw    = $clog2(CellCount);

  // Binary angle width; one turn is 2**AngleBits.
  localparam int AngleBits = 12;

  // Sine polynomial coefficients, Q.14.
  localparam logic [14:0] PolyA = 15'd25736;
  localparam logic [14:0] PolyB = 15'd10512;
  localparam logic [14:0] PolyC = 15'd1160;

  // Cell bytes.
  localparam logic [7:0] EmptyCell = 8'h20;
  localparam logic [7:0] DigitZero = 8'h30;
  localparam logic [7:0] DigitNine = 8'h39;

  // Divider widths: dividend/quotient and divisor.
  localparam int DivNw = 22;
  localparam int DivDw = 17;

  // Item modes.
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeCast = 1'b1;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    RegCameraX   = 4'd0,
    RegCameraY   = 4'd1,
    RegViewDir   = 4'd2,
    RegFov       = 4'd3,
    RegMaxDist   = 4'd4,
    RegStep      = 4'd5,
    RegWidth     = 4'd6,
    RegHeight    = 4'd7
  } cfg_reg_e;

  // Reset values of the registers.
  localparam logic [15:0] RstCameraX = 16'd14156;
  localparam logic [15:0] RstCameraY = 16'd9605;
  localparam logic [11:0] RstViewDir = 12'd512;
  localparam logic [11:0] RstFov     = 12'd652;
  localparam logic [16:0] RstMaxDist = 17'd81920;
  localparam logic [11:0] RstStep    = 12'd41;
  localparam logic [9:0]  RstWidth   = 10'd768;
  localparam logic [9:0]  RstHeight  = 10'd768;

  // Gray shade of a wall digit.
  function automatic logic [7:0] gray_of(input logic [3:0] wall);
    logic [8:0] g;
    g = 9'(wall) * 9'd20 + 9'd20;
    return g[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/grid_ray_column_caster.sv -----
// Load request: written to the map store when it is taken, no result.
// Cast request: set-up (angle division, cosine and sine), then march steps (map read
// loop), then the depth cosine and the height division.
// One request is worked on at a time; a finished result waits in the output register.
// Reset is asynchronous, active low; it restores the register defaults and
// leaves the map store undefined until it is loaded.
// ----------------------------------------------------------------------------
// grid_ray_column_caster
// Fixed-step ray march over a grid map, one screen column per cast request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module grid_ray_column_caster (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration writes.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  // Request channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  cell_index_i,
  input  wire logic [7:0]  cell_value_i,
  input  wire logic [9:0]  column_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [9:0]       out_column_o,
  output logic             hit_o,
  output logic [3:0]       wall_index_o,
  output logic [7:0]       gray_level_o,
  output logic [16:0]      depth_o,
  output logic [11:0]      column_height_o,
  output logic signed [11:0] top_row_o
);

  localparam int AB = rgc_pkg::AngleBits;
  localparam logic [AB-1:0] Quarter = AB'(1 << (AB - 2));
  localparam int CoordW = 8;

  typedef enum logic [4:0] {
    S_IDLE, S_FMUL, S_RDIV_GO, S_RDIV_WAIT, S_COS_GO, S_COS_WAIT,
    S_SIN_GO, S_SIN_WAIT, S_TEST, S_MULY, S_ADDR, S_CELL,
    S_CREL_GO, S_CREL_WAIT, S_DMUL, S_DEPTH, S_HDIV_WAIT, S_OUT
  } cast_state_e;

  cast_state_e state_q;

  // Configuration registers.
  logic [15:0] cam_x_q, cam_y_q;
  logic [11:0] vd_q, fov_q, step_q;
  logic [16:0] maxd_q;
  logic [9:0]  width_q, height_q;

  // Cast working registers.
  logic [9:0]          col_q;
  logic [AB-1:0]       rel_q;
  logic signed [15:0]  cs_q, sn_q, crel_q;
  logic [17:0]         reach_q;
  logic signed [19:0]  px_q;
  logic signed [35:0]  p_q;
  logic                hit_q;
  logic [3:0]          wall_q;
  logic [16:0]         depth_q;
  logic [11:0]         tall_q;

  // Output register.
  logic        out_valid_q, out_hit_q;
  logic [9:0]  out_col_q;
  logic [3:0]  out_wall_q;
  logic [7:0]  out_gray_q;
  logic [16:0] out_depth_q;
  logic [11:0] out_tall_q, out_top_q;

  // Shared multiplier.
  logic signed [18:0] mul_a;
  logic signed [16:0] mul_b;

  // Sub-units.
  logic          sin_start, sin_done;
  logic [AB-1:0] sin_angle;
  logic signed [15:0] sin_value;
  logic          div_start, div_busy, div_done;
  logic [rgc_pkg::DivNw-1:0] div_dividend, div_quot;
  logic [rgc_pkg::DivDw-1:0] div_divisor;

  // Map store.
  logic                       ram_we;
  logic [rgc_pkg::CellAw-1:0] ram_raddr;
  logic [7:0]                 ram_rdata;

  // Step logic.
  logic accept, out_free;
  logic [9:0]         cols;
  logic [11:0]        stride;
  logic signed [19:0] py;
  logic [CoordW-1:0]  gx, gy;
  logic               outside;
  logic signed [21:0] dfull;
  logic [16:0]        depth_new;
  logic [11:0]        top_new;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cols        = (width_q == '0) ? 10'd1 : width_q;
  assign stride      = (step_q == '0) ? 12'd1 : step_q;

  // Multiplier operands by state.
  always_comb begin
    unique case (state_q)
      S_FMUL:  begin mul_a = $signed(19'(fov_q));      mul_b = $signed(17'(col_q)); end
      S_TEST:  begin mul_a = $signed({1'b0, reach_q}); mul_b = 17'(cs_q);          end
      S_MULY:  begin mul_a = $signed({1'b0, reach_q}); mul_b = 17'(sn_q);          end
      S_DMUL:  begin mul_a = $signed({1'b0, reach_q}); mul_b = 17'(crel_q);        end
      default: begin mul_a = '0;                       mul_b = '0;                 end
    endcase
  end

  // Ray position and map bounds.
  always_comb begin
    py        = $signed({4'b0, cam_y_q}) + $signed(p_q[33:14]);
    gx        = px_q[19:12];
    gy        = py[19:12];
    outside   = px_q[19] || py[19] ||
                (32'(gx) >= rgc_pkg::MapSide) || (32'(gy) >= rgc_pkg::MapSide);
    ram_raddr = rgc_pkg::CellAw'(32'(gy) * rgc_pkg::MapSide + 32'(gx));
    dfull     = p_q[35:14];
    depth_new = dfull[21] ? 17'd0 : dfull[16:0];
    top_new   = {3'b0, height_q[9:1]} - {1'b0, tall_q[11:1]};
  end

  // Sine and divider requests.
  always_comb begin
    sin_start = (state_q == S_COS_GO) || (state_q == S_SIN_GO) ||
                (state_q == S_CREL_GO);
    unique case (state_q)
      S_COS_GO:  sin_angle = AB'(vd_q) + rel_q + Quarter;
      S_SIN_GO:  sin_angle = AB'(vd_q) + rel_q;
      default:   sin_angle = rel_q + Quarter;
    endcase
    div_start = (state_q == S_RDIV_GO) || ((state_q == S_DEPTH) && (depth_new != '0));
    if (state_q == S_RDIV_GO) begin
      div_dividend = p_q[rgc_pkg::DivNw-1:0];
      div_divisor  = rgc_pkg::DivDw'(cols);
    end else begin
      div_dividend = {height_q, 12'b0};
      div_divisor  = depth_new;
    end
  end

  assign ram_we = accept && (mode_i == rgc_pkg::ModeLoad) &&
                  (32'(cell_index_i) < rgc_pkg::CellCount);

  // Sequencer, working registers, configuration and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cam_x_q     <= rgc_pkg::RstCameraX;
      cam_y_q     <= rgc_pkg::RstCameraY;
      vd_q        <= rgc_pkg::RstViewDir;
      fov_q       <= rgc_pkg::RstFov;
      maxd_q      <= rgc_pkg::RstMaxDist;
      step_q      <= rgc_pkg::RstStep;
      width_q     <= rgc_pkg::RstWidth;
      height_q    <= rgc_pkg::RstHeight;
      col_q       <= '0;
      rel_q       <= '0;
      cs_q        <= '0;
      sn_q        <= '0;
      crel_q      <= '0;
      reach_q     <= '0;
      px_q        <= '0;
      p_q         <= '0;
      hit_q       <= 1'b0;
      wall_q      <= '0;
      depth_q     <= '0;
      tall_q      <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_col_q   <= '0;
      out_wall_q  <= '0;
      out_gray_q  <= '0;
      out_depth_q <= '0;
      out_tall_q  <= '0;
      out_top_q   <= '0;
    end else begin
      p_q <= mul_a * mul_b;

      // Configuration writes; unknown indexes are dropped.
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rgc_pkg::RegCameraX: cam_x_q  <= cfg_data_i[15:0];
          rgc_pkg::RegCameraY: cam_y_q  <= cfg_data_i[15:0];
          rgc_pkg::RegViewDir: vd_q     <= cfg_data_i[11:0];
          rgc_pkg::RegFov:     fov_q    <= cfg_data_i[11:0];
          rgc_pkg::RegMaxDist: maxd_q   <= cfg_data_i;
          rgc_pkg::RegStep:    step_q   <= cfg_data_i[11:0];
          rgc_pkg::RegWidth:   width_q  <= cfg_data_i[9:0];
          rgc_pkg::RegHeight:  height_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end

      // A taken result empties the register unless a new one moves in.
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept && (mode_i == rgc_pkg::ModeCast)) begin
            col_q   <= column_i;
            state_q <= S_FMUL;
          end
        end
        S_FMUL:    state_q <= S_RDIV_GO;
        S_RDIV_GO: state_q <= S_RDIV_WAIT;
        S_RDIV_WAIT: begin
          if (div_done) begin
            rel_q   <= AB'(div_quot) - AB'(fov_q >> 1);
            state_q <= S_COS_GO;
          end
        end
        S_COS_GO: state_q <= S_COS_WAIT;
        S_COS_WAIT: begin
          if (sin_done) begin
            cs_q    <= sin_value;
            state_q <= S_SIN_GO;
          end
        end
        S_SIN_GO: state_q <= S_SIN_WAIT;
        S_SIN_WAIT: begin
          if (sin_done) begin
            sn_q    <= sin_value;
            reach_q <= '0;
            state_q <= S_TEST;
          end
        end
        // Length limit; the x product is formed on the way out.
        S_TEST: begin
          if (reach_q >= {1'b0, maxd_q}) begin
            hit_q   <= 1'b0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_MULY;
          end
        end
        S_MULY: begin
          px_q    <= $signed({4'b0, cam_x_q}) + $signed(p_q[33:14]);
          state_q <= S_ADDR;
        end
        // The map edge is a wall of digit zero; otherwise read the cell.
        S_ADDR: begin
          if (outside) begin
            hit_q   <= 1'b1;
            wall_q  <= '0;
            state_q <= S_CREL_GO;
          end else begin
            state_q <= S_CELL;
          end
        end
        S_CELL: begin
          if (ram_rdata != rgc_pkg::EmptyCell) begin
            hit_q <= 1'b1;
            if ((ram_rdata >= rgc_pkg::DigitZero) && (ram_rdata <= rgc_pkg::DigitNine)) begin
              wall_q <= 4'(ram_rdata - rgc_pkg::DigitZero);
            end else begin
              wall_q <= '0;
            end
            state_q <= S_CREL_GO;
          end else begin
            reach_q <= reach_q + 18'(stride);
            state_q <= S_TEST;
          end
        end
        S_CREL_GO: state_q <= S_CREL_WAIT;
        S_CREL_WAIT: begin
          if (sin_done) begin
            crel_q  <= sin_value;
            state_q <= S_DMUL;
          end
        end
        S_DMUL: state_q <= S_DEPTH;
        S_DEPTH: begin
          depth_q <= depth_new;
          if (depth_new == '0) begin
            tall_q  <= 12'd4095;
            state_q <= S_OUT;
          end else begin
            state_q <= S_HDIV_WAIT;
          end
        end
        S_HDIV_WAIT: begin
          if (div_done) begin
            tall_q  <= (div_quot > 22'd4095) ? 12'd4095 : div_quot[11:0];
            state_q <= S_OUT;
          end
        end
        // Hand the result to the output register once it is free.
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_col_q   <= col_q;
            out_hit_q   <= hit_q;
            if (hit_q) begin
              out_wall_q  <= wall_q;
              out_gray_q  <= rgc_pkg::gray_of(wall_q);
              out_depth_q <= depth_q;
              out_tall_q  <= tall_q;
              out_top_q   <= top_new;
            end else begin
              out_wall_q  <= '0;
              out_gray_q  <= '0;
              out_depth_q <= '0;
              out_tall_q  <= '0;
              out_top_q   <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  rgc_map_ram u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cell_index_i[rgc_pkg::CellAw-1:0]),
    .wdata_i (cell_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rgc_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sin_start),
    .angle_i (sin_angle),
    .done_o  (sin_done),
    .value_o (sin_value)
  );

  rgc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign out_valid_o     = out_valid_q;
  assign out_column_o    = out_col_q;
  assign hit_o           = out_hit_q;
  assign wall_index_o    = out_wall_q;
  assign gray_level_o    = out_gray_q;
  assign depth_o         = out_depth_q;
  assign column_height_o = out_tall_q;
  assign top_row_o       = $signed(out_top_q);

  `RGC_ASSERT_IMP(a_miss_zero, out_valid_o && !hit_o,
                  (depth_o == '0) && (column_height_o == '0) && (top_row_o == '0))
  `RGC_ASSERT_IMP(a_cell_after_read, state_q == S_CELL, $past(state_q) == S_ADDR)
  `RGC_ASSERT_IMP(a_div_wait_busy, (state_q == S_RDIV_WAIT) && !div_done, div_busy)

endmodule

`default_nettype wire

// ----- rtl/rgc_map_ram.sv -----
// ----------------------------------------------------------------------------
// rgc_map_ram
// Map cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rgc_map_ram (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [rgc_pkg::CellAw-1:0] waddr_i,
  input  wire logic [7:0]                wdata_i,
  input  wire logic [rgc_pkg::CellAw-1:0] raddr_i,
  output logic      [7:0]                rdata_o
);

  logic [7:0] mem_q [rgc_pkg::CellCount];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/rgc_sine.sv -----
// ----------------------------------------------------------------------------
// rgc_sine
// Sequential Q.14 sine of a binary angle: four multiplies, one after another.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rgc_sine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rgc_pkg::AngleBits-1:0] angle_i,
  output logic                               done_o,
  output logic signed [15:0]                 value_o
);

  typedef enum logic [2:0] {S_IDLE, S_U2, S_T1, S_T2, S_R} sine_state_e;

  sine_state_e state_q;
  logic [14:0] u_q, u2_q, acc_q;
  logic        neg_q, done_q;
  logic signed [15:0] value_q;

  logic [15:0] ph;
  logic [14:0] u_start;
  logic [14:0] mul_a, mul_b, sh;
  logic [29:0] prod;

  // Fold the angle into the first quadrant.
  always_comb begin
    ph      = 16'(angle_i) << (16 - rgc_pkg::AngleBits);
    u_start = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
  end

  // Shared multiplier, operands chosen by step.
  always_comb begin
    unique case (state_q)
      S_U2:    begin mul_a = u_q;          mul_b = u_q;   end
      S_T1:    begin mul_a = rgc_pkg::PolyC; mul_b = u2_q; end
      S_T2:    begin mul_a = u2_q;         mul_b = acc_q; end
      S_R:     begin mul_a = u_q;          mul_b = acc_q; end
      default: begin mul_a = '0;           mul_b = '0;    end
    endcase
    prod = 30'(mul_a) * 30'(mul_b);
    sh   = prod[28:14];
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      u_q     <= '0;
      u2_q    <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
      value_q <= '0;
    end else begin
      done_q <= (state_q == S_R);
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            u_q     <= u_start;
            neg_q   <= ph[15];
            state_q <= S_U2;
          end
        end
        S_U2: begin
          u2_q    <= sh;
          state_q <= S_T1;
        end
        S_T1: begin
          acc_q   <= rgc_pkg::PolyB - sh;
          state_q <= S_T2;
        end
        S_T2: begin
          acc_q   <= rgc_pkg::PolyA - sh;
          state_q <= S_R;
        end
        S_R: begin
          value_q <= neg_q ? -$signed({1'b0, sh}) : $signed({1'b0, sh});
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

  `RGC_ASSERT_IMP(a_sine_range, done_o,
                  (value_o <= 16'sd25736) && (value_o >= -16'sd25736))
  `RGC_ASSERT_NXT(a_sine_start, start_i && (state_q == S_IDLE), state_q == S_U2)

endmodule

`default_nettype wire

// ----- rtl/rgc_divider.sv -----
// ----------------------------------------------------------------------------
// rgc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rgc_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rgc_pkg::DivNw-1:0] dividend_i,
  input  wire logic [rgc_pkg::DivDw-1:0] divisor_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic      [rgc_pkg::DivNw-1:0] quotient_o
);

  localparam int CntW = $clog2(rgc_pkg::DivNw + 1);

  logic                      busy_q, done_q;
  logic [CntW-1:0]           cnt_q;
  logic [rgc_pkg::DivDw-1:0] rem_q, dsr_q;
  logic [rgc_pkg::DivNw-1:0] quo_q;

  logic [rgc_pkg::DivDw:0]   rem_sh, diff;
  logic                      qbit;

  // One trial subtraction.
  always_comb begin
    rem_sh = {rem_q, quo_q[rgc_pkg::DivNw-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    qbit   = !diff[rgc_pkg::DivDw];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(rgc_pkg::DivNw);
        rem_q  <= '0;
        dsr_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= qbit ? diff[rgc_pkg::DivDw-1:0] : rem_sh[rgc_pkg::DivDw-1:0];
        quo_q <= {quo_q[rgc_pkg::DivNw-2:0], qbit};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `RGC_ASSERT_IMP(a_div_no_restart, start_i, !busy_o)

endmodule

`default_nettype wire

// ----- tb/ray_cast_checker.sv -----
// ----------------------------------------------------------------------------
// ray_cast_checker
// Watches the configuration, request and result channels of the column caster.
// It keeps its own copy of the map and the view settings, works out the column
// that every cast request should give, and compares each result field by field.
// ----------------------------------------------------------------------------
module ray_cast_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [3:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               mode_i,
  input  logic [7:0]         cell_index_i,
  input  logic [7:0]         cell_value_i,
  input  logic [9:0]         column_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [9:0]         out_column_i,
  input  logic               hit_i,
  input  logic [3:0]         wall_index_i,
  input  logic [7:0]         gray_level_i,
  input  logic [16:0]        depth_i,
  input  logic [11:0]        column_height_i,
  input  logic signed [11:0] top_row_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0]  column;
    logic        hit;
    logic [3:0]  wall;
    logic [7:0]  gray;
    logic [16:0] depth;
    logic [11:0] height;
    logic [11:0] top;
  } wall_column_t;

  // Shadow copy of the view settings and the map.
  logic [15:0] cam_x, cam_y;
  logic [11:0] heading_base, view_span, stride_set;
  logic [16:0] reach_limit;
  logic [9:0]  cols_set, rows_set;
  logic [7:0]  grid [rgc_pkg::CellCount];

  wall_column_t expected_columns [$];

  // Q.14 sine of a 12-bit binary angle, by the odd polynomial over a quadrant.
  function automatic longint sine_q14(input logic [11:0] ang);
    logic [15:0] ph;
    longint unsigned u, u2, acc;
    ph = {ang, 4'b0};
    u = ph[13:0];
    if (ph[14]) begin
      u = 16384 - u;
    end
    u2 = (u * u) >> 14;
    acc = rgc_pkg::PolyB - ((rgc_pkg::PolyC * u2) >> 14);
    acc = rgc_pkg::PolyA - ((u2 * acc) >> 14);
    acc = (u * acc) >> 14;
    return ph[15] ? -longint'(acc) : longint'(acc);
  endfunction

  function automatic longint cosine_q14(input logic [11:0] ang);
    return sine_q14(ang + 12'd1024);
  endfunction

  // Floor of reach times a Q.14 factor; the arithmetic shift rounds down.
  function automatic longint scale_down(input longint reach, input longint trig);
    return (reach * trig) >>> 14;
  endfunction

  function automatic wall_column_t cast_column(input logic [9:0] col);
    wall_column_t r;
    longint cols, stride, reach, cs, sn, px, py, d, tall;
    logic [11:0] rel, heading;
    logic [7:0] cell_byte;
    bit found;
    r = '0;
    r.column = col;
    found = 0;
    cols = (cols_set == 0) ? 1 : cols_set;
    stride = (stride_set == 0) ? 1 : stride_set;
    rel = 12'((longint'(view_span) * col) / cols - (view_span >> 1));
    heading = heading_base + rel;
    cs = cosine_q14(heading);
    sn = sine_q14(heading);
    for (reach = 0; reach < reach_limit; reach += stride) begin
      px = cam_x + scale_down(reach, cs);
      py = cam_y + scale_down(reach, sn);
      if (px < 0 || py < 0 || (px >>> 12) >= rgc_pkg::MapSide ||
          (py >>> 12) >= rgc_pkg::MapSide) begin
        found = 1;
        break;
      end
      cell_byte = grid[(py >>> 12) * rgc_pkg::MapSide + (px >>> 12)];
      if (cell_byte != rgc_pkg::EmptyCell) begin
        found = 1;
        if (cell_byte >= rgc_pkg::DigitZero && cell_byte <= rgc_pkg::DigitNine) begin
          r.wall = 4'(cell_byte - rgc_pkg::DigitZero);
        end
        break;
      end
    end
    if (!found) begin
      return r;
    end
    d = scale_down(reach, cosine_q14(rel));
    if (d < 0) begin
      d = 0;
    end
    d = d & 17'h1ffff;
    if (d == 0) begin
      tall = 4095;
    end else begin
      tall = (longint'(rows_set) << 12) / d;
      if (tall > 4095) begin
        tall = 4095;
      end
    end
    r.hit = 1'b1;
    r.gray = 8'(20 * (r.wall + 1));
    r.depth = 17'(d);
    r.height = 12'(tall);
    r.top = 12'(longint'(rows_set >> 1) - (tall >> 1));
    return r;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Track every accepted write, request and result.
  always @(posedge clk_i or negedge rst_ni) begin
    wall_column_t exp_c;
    if (!rst_ni) begin
      cam_x = rgc_pkg::RstCameraX;
      cam_y = rgc_pkg::RstCameraY;
      heading_base = rgc_pkg::RstViewDir;
      view_span = rgc_pkg::RstFov;
      reach_limit = rgc_pkg::RstMaxDist;
      stride_set = rgc_pkg::RstStep;
      cols_set = rgc_pkg::RstWidth;
      rows_set = rgc_pkg::RstHeight;
      expected_columns.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rgc_pkg::RegCameraX: cam_x = cfg_data_i[15:0];
          rgc_pkg::RegCameraY: cam_y = cfg_data_i[15:0];
          rgc_pkg::RegViewDir: heading_base = cfg_data_i[11:0];
          rgc_pkg::RegFov:     view_span = cfg_data_i[11:0];
          rgc_pkg::RegMaxDist: reach_limit = cfg_data_i;
          rgc_pkg::RegStep:    stride_set = cfg_data_i[11:0];
          rgc_pkg::RegWidth:   cols_set = cfg_data_i[9:0];
          rgc_pkg::RegHeight:  rows_set = cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == rgc_pkg::ModeLoad) begin
          if (cell_index_i < rgc_pkg::CellCount) begin
            grid[cell_index_i] = cell_value_i;
          end
        end else begin
          expected_columns = {expected_columns, cast_column(column_i)};
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_columns.size() == 0) begin
          $error("result for column %0d with no cast request waiting", out_column_i);
          fail_count_o++;
        end else begin
          exp_c = expected_columns[0];
          expected_columns.delete(0);
          check_field("out_column", exp_c.column, out_column_i);
          check_field("hit", exp_c.hit, hit_i);
          check_field("wall_index", exp_c.wall, wall_index_i);
          check_field("gray_level", exp_c.gray, gray_level_i);
          check_field("depth", exp_c.depth, depth_i);
          check_field("column_height", exp_c.height, column_height_i);
          check_field("top_row", $signed(exp_c.top), top_row_i);
        end
      end
    end
    pending_o = expected_columns.size();
  end

endmodule

// ----- tb/tb_grid_ray_column_caster.sv -----
// ----------------------------------------------------------------------------
// tb_grid_ray_column_caster
// Loads a random map, moves the camera through several view settings, and casts
// directed and random columns with random gaps and result back-pressure.
// ----------------------------------------------------------------------------
module tb_grid_ray_column_caster;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] UnusedReg = 4'd12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [3:0] cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic mode_i = rgc_pkg::ModeLoad;
  logic [7:0] cell_index_i = '0;
  logic [7:0] cell_value_i = '0;
  logic [9:0] column_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [9:0] out_column_o;
  logic hit_o;
  logic [3:0] wall_index_o;
  logic [7:0] gray_level_o;
  logic [16:0] depth_o;
  logic [11:0] column_height_o;
  logic signed [11:0] top_row_o;
  int unsigned pending_casts, fail_count;
  bit send_quiet = 0;
  bit hold_results = 0;

  grid_ray_column_caster uut (.*);

  ray_cast_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .cell_index_i, .cell_value_i,
    .column_i, .out_valid_i(out_valid_o), .out_stall_i, .out_column_i(out_column_o),
    .hit_i(hit_o), .wall_index_i(wall_index_o), .gray_level_i(gray_level_o),
    .depth_i(depth_o), .column_height_i(column_height_o), .top_row_i(top_row_o),
    .pending_o(pending_casts), .fail_count_o(fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_results) begin
        out_stall_i <= 1'b1;
        repeat (20000) @(negedge clk_i);
        hold_results = 0;
      end
      out_stall_i <= ((cyc % 20000) > 12000) ? 1'b0 : ($urandom_range(99) < 15);
    end
  end

  task automatic write_reg(input logic [3:0] idx, input logic [16:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Entered and left at a falling edge; valid stays high across back-to-back requests.
  task automatic send_request(input logic m, input logic [7:0] idx, input logic [7:0] val,
                              input logic [9:0] col);
    if (!send_quiet && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    cell_index_i <= idx;
    cell_value_i <= val;
    column_i <= col;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic load_cell(input logic [7:0] idx, input logic [7:0] val);
    send_request(rgc_pkg::ModeLoad, idx, val, 10'($urandom));
  endtask

  task automatic cast(input logic [9:0] col);
    send_request(rgc_pkg::ModeCast, 8'($urandom), 8'($urandom), col);
  endtask

  function automatic logic [7:0] random_cell();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return rgc_pkg::EmptyCell;
    if (r < 88) return rgc_pkg::DigitZero + 8'($urandom_range(9));
    return 8'($urandom);
  endfunction

  // Settings are only changed once the block has nothing in flight.
  task automatic set_view(input logic [15:0] x, input logic [15:0] y, input logic [11:0] dir,
                          input logic [11:0] fov, input logic [16:0] maxd,
                          input logic [11:0] step, input logic [9:0] w, input logic [9:0] h);
    in_valid_i <= 1'b0;
    wait (pending_casts == 0);
    repeat (50) @(negedge clk_i);
    write_reg(rgc_pkg::RegCameraX, 17'(x));
    write_reg(rgc_pkg::RegCameraY, 17'(y));
    write_reg(rgc_pkg::RegViewDir, 17'(dir));
    write_reg(rgc_pkg::RegFov, 17'(fov));
    write_reg(rgc_pkg::RegMaxDist, maxd);
    write_reg(rgc_pkg::RegStep, 17'(step));
    write_reg(rgc_pkg::RegWidth, 17'(w));
    write_reg(rgc_pkg::RegHeight, 17'(h));
    write_reg(UnusedReg, 17'($urandom));
  endtask

  task automatic random_phase(input int unsigned count);
    logic [16:0] maxd;
    logic [11:0] step;
    logic [9:0] w;
    maxd = 17'($urandom);
    step = 12'(maxd / 400 + $urandom_range(1, 200));
    if (step == 0) step = 12'd4095;
    w = 10'($urandom_range(1, 1023));
    set_view(16'($urandom), 16'($urandom), 12'($urandom), 12'($urandom_range(0, 1200)),
             maxd, step, w, 10'($urandom));
    repeat (count) begin
      if ($urandom_range(99) < 12) load_cell(8'($urandom), random_cell());
      else if ($urandom_range(99) < 85) cast(10'($urandom_range(0, w - 1)));
      else cast(10'($urandom));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned guard;
    @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill the whole map before any cast, then a few hand-picked cells.
    send_quiet = 1;
    for (int i = 0; i < rgc_pkg::CellCount; i++) load_cell(8'(i), random_cell());
    send_quiet = 0;
    load_cell(8'd0, 8'hff);
    load_cell(8'd255, 8'h00);
    load_cell(8'd51, rgc_pkg::DigitNine);
    load_cell(8'd52, rgc_pkg::DigitZero);

    // Reset view: screen edges, a column past the width, the top column code.
    cast(10'd0);
    cast(10'd767);
    cast(10'd384);
    cast(10'd800);
    cast(10'd1023);

    // Top corner, facing back and fully wide: map edge and the widest view.
    set_view(16'd0, 16'd0, 12'd2048, 12'd4095, 17'd131071, 12'd4095, 10'd1023, 10'd1023);
    cast(10'd0);
    cast(10'd511);
    cast(10'd1022);
    cast(10'd1023);
    // Far corner, zero width, zero step and zero height, with a short reach.
    set_view(16'hffff, 16'hffff, 12'd0, 12'd0, 17'd600, 12'd0, 10'd0, 10'd0);
    cast(10'd0);
    cast(10'd5);
    // No reach at all: nothing can be hit.
    set_view(16'd30000, 16'd30000, 12'd4095, 12'd652, 17'd0, 12'd1, 10'd1, 10'd1);
    cast(10'd0);
    cast(10'd1);

    // Reset-like view with a long quiet stretch and one long result hold-off.
    set_view(rgc_pkg::RstCameraX, rgc_pkg::RstCameraY, rgc_pkg::RstViewDir,
             rgc_pkg::RstFov, rgc_pkg::RstMaxDist, rgc_pkg::RstStep,
             rgc_pkg::RstWidth, rgc_pkg::RstHeight);
    send_quiet = 1;
    hold_results = 1;
    repeat (8) cast(10'($urandom_range(0, 767)));
    send_quiet = 0;

    // Random views.
    repeat (2) random_phase(6);
    in_valid_i <= 1'b0;

    guard = 0;
    while (pending_casts != 0 && guard < 2000000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending_casts == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rgc_pkg.sv
rtl/rgc_map_ram.sv
rtl/rgc_sine.sv
rtl/rgc_divider.sv
rtl/grid_ray_column_caster.sv
tb/ray_cast_checker.sv
tb/tb_grid_ray_column_caster.sv
